// ----- src/hldmq_pkg.sv -----
// package: shared types, constants and codes of the hit list queue
`default_nettype none

package hldmq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int DIST_W  = 32;
    localparam int UV_W    = 17;
    localparam int TAG_W   = 8;
    localparam int ORDER_W = 32;
    localparam int STAT_W  = 3;

    // tdata: distance, u, v, tag from the lowest bit, padded to whole bytes
    localparam int PAYLOAD_W = DIST_W + 2 * UV_W + TAG_W;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_DIST_TOL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_UV_TOL   = 1'b1;

    localparam logic [DIST_W-1:0] DIST_TOL_RESET = 32'd33;
    localparam logic [UV_W-1:0]   UV_TOL_RESET   = 17'd7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_DUPLICATE = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_POPPED    = 3'd3,
        STATUS_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // one stored hit, as it sits in the entry memory
    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic [TAG_W-1:0]   surface;
        logic [UV_W-1:0]    v;
        logic [UV_W-1:0]    u;
        logic [DIST_W-1:0]  distance;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // verdict of the compare unit on one stored entry
    typedef struct packed {
        logic dup;     // entry within tolerance in distance, u or v
        logic better;  // entry beats the current pop candidate
    } cmp_flags_t;

endpackage

`default_nettype wire

// ----- src/hldmq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module hldmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/hldmq_cmp.sv -----
// compare unit: duplicate test against the hit and min test against the pop candidate
`default_nettype none

module hldmq_cmp (
    input  wire logic [hldmq_pkg::DIST_W-1:0]  hit_distance,
    input  wire logic [hldmq_pkg::UV_W-1:0]    hit_u,
    input  wire logic [hldmq_pkg::UV_W-1:0]    hit_v,
    input  wire logic [hldmq_pkg::DIST_W-1:0]  dist_tol,
    input  wire logic [hldmq_pkg::UV_W-1:0]    uv_tol,
    input  wire hldmq_pkg::entry_t             entry,
    input  wire logic                          best_found,
    input  wire logic [hldmq_pkg::DIST_W-1:0]  best_distance,
    input  wire logic [hldmq_pkg::ORDER_W-1:0] best_order,
    output hldmq_pkg::cmp_flags_t              flags
);

    localparam int DD_W = hldmq_pkg::DIST_W + 1;
    localparam int UD_W = hldmq_pkg::UV_W + 1;

    logic [DD_W-1:0] d_diff, d_abs;
    logic [UD_W-1:0] u_diff, u_abs, v_diff, v_abs;
    logic            d_near, u_near, v_near;
    logic            d_less, d_equal;

    always_comb begin
        // sign-extended distance difference fits 33 bits, magnitude too
        d_diff = {hit_distance[hldmq_pkg::DIST_W-1], hit_distance}
               - {entry.distance[hldmq_pkg::DIST_W-1], entry.distance};
        d_abs  = d_diff[DD_W-1] ? (~d_diff + DD_W'(1)) : d_diff;
        u_diff = {1'b0, hit_u} - {1'b0, entry.u};
        u_abs  = u_diff[UD_W-1] ? (~u_diff + UD_W'(1)) : u_diff;
        v_diff = {1'b0, hit_v} - {1'b0, entry.v};
        v_abs  = v_diff[UD_W-1] ? (~v_diff + UD_W'(1)) : v_diff;

        d_near = d_abs < {1'b0, dist_tol};
        u_near = u_abs < {1'b0, uv_tol};
        v_near = v_abs < {1'b0, uv_tol};

        d_less  = $signed(entry.distance) < $signed(best_distance);
        d_equal = entry.distance == best_distance;

        flags.dup    = d_near | u_near | v_near;
        flags.better = !best_found | d_less | (d_equal & (entry.order > best_order));
    end

endmodule

`default_nettype wire

// ----- src/hit_list_dedup_min_queue_unit.sv -----
// top level: hit store with tolerance dedup on insert and nearest-hit pop
// items are handled one at a time: a new beat is taken only in idle, after the
//   scan of the entry ram, one stored entry read and compared per cycle, and
//   after the result has been placed in the output register
// reset: aresetn low clears the valid bits, sequence stamp, fsm, output beat and
//   restores the tolerance registers; the entry ram itself needs no clearing
`default_nettype none

module hit_list_dedup_min_queue_unit #(
    parameter int DEPTH = hldmq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [hldmq_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  wire logic [hldmq_pkg::CFG_W-1:0]         cfg_wr_data,
    // input beats
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // hit_distance [31:0], hit_u [48:32], hit_v [65:49], surface_tag [73:66]
    input  wire logic [hldmq_pkg::TDATA_W-1:0]       s_tdata,
    // operation [0]
    input  wire logic                                s_tuser,
    // result beats
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // out_distance [31:0], out_u [48:32], out_v [65:49], out_surface [73:66]
    output logic [hldmq_pkg::TDATA_W-1:0]            m_tdata,
    // status [2:0]
    output logic [hldmq_pkg::STAT_W-1:0]             m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = hldmq_pkg::DIST_W;
    localparam int UW = hldmq_pkg::UV_W;
    localparam int TW = hldmq_pkg::TAG_W;
    localparam int OW = hldmq_pkg::ORDER_W;

    // tolerance registers
    logic [DW-1:0] dist_tol_reg;
    logic [UW-1:0] uv_tol_reg;

    // latched input beat
    logic          op_reg;
    logic [DW-1:0] hit_dist_reg;
    logic [UW-1:0] hit_u_reg;
    logic [UW-1:0] hit_v_reg;
    logic [TW-1:0] hit_tag_reg;

    // per-entry valid bits and insert stamp
    logic [DEPTH-1:0] valid_reg;
    logic [OW-1:0]    seq_reg;

    // scan counter: issues read at cnt, evaluates ram data of cnt-1
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] eval_idx;
    logic          eval_en;
    logic          scan_done;

    // scan accumulators
    logic          dup_reg;
    logic          free_found_reg;
    logic [AW-1:0] free_idx_reg;
    logic          best_found_reg;
    logic [AW-1:0] best_idx_reg;
    hldmq_pkg::entry_t best_reg;

    // output beat register
    logic                         m_tvalid_reg;
    logic [hldmq_pkg::STAT_W-1:0] m_status_reg;
    logic [hldmq_pkg::TDATA_W-1:0] m_data_reg;

    hldmq_pkg::state_t     state_reg, state_next;
    hldmq_pkg::entry_t     rd_entry, wr_entry;
    hldmq_pkg::cmp_flags_t flags;
    logic                  commit;
    logic                  ram_we;
    logic                  out_free;
    logic                  in_beat;

    assign in_beat  = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg | m_tready;
    assign eval_idx = AW'(cnt_reg - CW'(1));
    assign eval_en  = (state_reg == hldmq_pkg::ST_SCAN) && (cnt_reg != '0);
    assign scan_done = cnt_reg == CW'(DEPTH);

    // a stored entry is only written at the end of an item, after its scan,
    // so a read never meets a write to the same entry in flight
    assign ram_we = commit && (op_reg == hldmq_pkg::OP_INSERT) && !dup_reg && free_found_reg;

    assign wr_entry = '{order:    seq_reg,
                        surface:  hit_tag_reg,
                        v:        hit_v_reg,
                        u:        hit_u_reg,
                        distance: hit_dist_reg};

    hldmq_ram #(
        .WIDTH (hldmq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (wr_entry),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    hldmq_cmp u_cmp (
        .hit_distance  (hit_dist_reg),
        .hit_u         (hit_u_reg),
        .hit_v         (hit_v_reg),
        .dist_tol      (dist_tol_reg),
        .uv_tol        (uv_tol_reg),
        .entry         (rd_entry),
        .best_found    (best_found_reg),
        .best_distance (best_reg.distance),
        .best_order    (best_reg.order),
        .flags         (flags)
    );

    // fsm: idle takes a beat, scan walks the ram, finish waits for the output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hldmq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            hldmq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = hldmq_pkg::ST_SCAN;
                end
            end
            hldmq_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = hldmq_pkg::ST_FINISH;
                end
            end
            hldmq_pkg::ST_FINISH: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = hldmq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hldmq_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_tol_reg <= hldmq_pkg::DIST_TOL_RESET;
            uv_tol_reg   <= hldmq_pkg::UV_TOL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                hldmq_pkg::REG_DIST_TOL: dist_tol_reg <= cfg_wr_data[DW-1:0];
                hldmq_pkg::REG_UV_TOL:   uv_tol_reg   <= cfg_wr_data[UW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input latch
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            op_reg       <= s_tuser;
            hit_dist_reg <= s_tdata[DW-1:0];
            hit_u_reg    <= s_tdata[DW +: UW];
            hit_v_reg    <= s_tdata[DW+UW +: UW];
            hit_tag_reg  <= s_tdata[DW+2*UW +: TW];
        end
    end

    // scan counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (in_beat) begin
            cnt_reg <= '0;
        end else if (state_reg == hldmq_pkg::ST_SCAN && !scan_done) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // accumulators: duplicate flag, lowest free slot, pop candidate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end else if (in_beat) begin
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end else if (eval_en) begin
            if (valid_reg[eval_idx]) begin
                if (flags.dup) begin
                    dup_reg <= 1'b1;
                end
                if (flags.better) begin
                    best_found_reg <= 1'b1;
                end
            end else if (!free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_en) begin
            if (valid_reg[eval_idx] && flags.better) begin
                best_idx_reg <= eval_idx;
                best_reg     <= rd_entry;
            end
            if (!valid_reg[eval_idx] && !free_found_reg) begin
                free_idx_reg <= eval_idx;
            end
        end
    end

    // valid bits and insert stamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            seq_reg   <= '0;
        end else if (commit) begin
            if (ram_we) begin
                valid_reg[free_idx_reg] <= 1'b1;
                seq_reg                 <= seq_reg + OW'(1);
            end else if (op_reg == hldmq_pkg::OP_POP && best_found_reg) begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // output beat register, payload zero unless popped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= '0;
            if (op_reg == hldmq_pkg::OP_INSERT) begin
                if (dup_reg) begin
                    m_status_reg <= hldmq_pkg::STATUS_DUPLICATE;
                end else if (!free_found_reg) begin
                    m_status_reg <= hldmq_pkg::STATUS_FULL;
                end else begin
                    m_status_reg <= hldmq_pkg::STATUS_INSERTED;
                end
            end else if (best_found_reg) begin
                m_status_reg <= hldmq_pkg::STATUS_POPPED;
                m_data_reg   <= hldmq_pkg::TDATA_W'({best_reg.surface, best_reg.v,
                                                     best_reg.u, best_reg.distance});
            end else begin
                m_status_reg <= hldmq_pkg::STATUS_EMPTY;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire
